/* hdl/itlb_pkg.sv */
// Shared types and constants of the inbound translation table.
// Used by the controller, the datapath and the top level.
// Depends on nothing.
package itlb_pkg;

  localparam int ITLB_ENTRIES      = 64;
  localparam int ITLB_WINDOW_BYTES = 4096;

  localparam int PAGE_BITS   = 14;
  localparam int MAX_ACCESS  = 8;
  localparam int SLOT_BITS   = 6;   // 64-byte slot per entry
  localparam int IDX_BITS    = 6;   // translate index width
  localparam int FRAME_W     = 52;
  localparam int ATTR_W      = 12;
  localparam int FRAME_SHIFT = 12;

  localparam logic [SLOT_BITS-1:0] ATTR_OFFSET = 6'd32;
  localparam logic [3:0]           ATTR_LEN    = 4'd4;

  localparam logic [FRAME_W-1:0] FRAME0_RST = FRAME_W'(64'h8000_0000 >> FRAME_SHIFT);
  localparam logic [ATTR_W-1:0]  ATTR0_RST  = 12'h100;

  localparam logic [63:0] PG_OFFSET_MASK = (64'd1 << PAGE_BITS) - 64'd1;

  typedef enum logic [1:0] {
    FUNC_RD    = 2'd0,
    FUNC_WR    = 2'd1,
    FUNC_XLATE = 2'd2,
    FUNC_BAD   = 2'd3
  } itlb_func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ADDR_ERR = 2'd1,
    ST_CMD_ERR  = 2'd2
  } itlb_status_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_item;
    logic idx_clr;
    logic clear_step;
    logic wr_step;
    logic rd_issue;
    logic rd_slot;
    logic rd_capture;
    logic tbl_read;
    logic rebuild_wr;
    logic attr_wr;
    logic res_load;
  } itlb_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    itlb_func_t func;
    logic       len_zero;
    logic       len_bad;
    logic       overrun;
    logic       byte_last;
    logic       rb_last;
    logic       rebuild_hit;
    logic       attr_hit;
    logic       clear_last;
  } itlb_sts_t;

endpackage

/* hdl/itlb_in_if.sv */
// Request channel of the inbound translation table: valid/ready plus request fields.
// Depends on nothing.
interface itlb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] address;
  logic [3:0]  length;
  logic [63:0] write_data;

  modport source (output valid, input ready, output func, output address,
                  output length, output write_data);
  modport sink   (input valid, output ready, input func, input address,
                  input length, input write_data);
endinterface

/* hdl/itlb_out_if.sv */
// Response channel of the inbound translation table: valid/ready plus result fields.
// Depends on nothing.
interface itlb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] read_data;
  logic [63:0] translated_address;
  logic [11:0] user_bits;

  modport source (output valid, input ready, output status, output read_data,
                  output translated_address, output user_bits);
  modport sink   (input valid, output ready, input status, input read_data,
                  input translated_address, input user_bits);
endinterface

/* hdl/inbound_tlb_16k_page.sv */
// Inbound translation table with a byte-addressed register window: one request
// in, one response out per item. A controller sequences a datapath that holds a
// single-port byte window memory and the entry tables. After reset the block
// sweeps the window of WINDOW_BYTES bytes (4096 by default) to zero, one byte per
// cycle, and takes no request until the sweep ends. A translate passes through
// decode and the registered table read before its result goes to the output
// register. A window read issues and then captures each byte in turn, and a
// write stores one byte per cycle; a write that starts in the first eight bytes
// of an entry slot then reads the eight slot bytes back and rebuilds the entry.
// Errors go from decode straight to the response. A response waits in an output
// register, and the next request is taken while it waits.
module inbound_tlb_16k_page
  import itlb_pkg::*;
#(
  parameter int ENTRIES      = ITLB_ENTRIES,
  parameter int WINDOW_BYTES = ITLB_WINDOW_BYTES
) (
  input  logic     clk,
  input  logic     rst_n,
  itlb_in_if.sink  in_ch,
  itlb_out_if.source out_ch
);

  itlb_cmd_t cmd;
  itlb_sts_t sts;

  itlb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  itlb_dp #(
    .ENTRIES      (ENTRIES),
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_func                (in_ch.func),
    .in_address             (in_ch.address),
    .in_length              (in_ch.length),
    .in_write_data          (in_ch.write_data),
    .out_status             (out_ch.status),
    .out_read_data          (out_ch.read_data),
    .out_translated_address (out_ch.translated_address),
    .out_user_bits          (out_ch.user_bits)
  );

endmodule

/* hdl/itlb_ctrl.sv */
// Sequencer of the inbound translation table: clearing pass, window byte loops,
// entry rebuild, table lookup and output handshake. Depends on itlb_pkg.
module itlb_ctrl
  import itlb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output itlb_cmd_t cmd,
  input  itlb_sts_t sts
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RD_ISSUE,
    S_RD_CAP,
    S_WR,
    S_POST_WR,
    S_RB_ISSUE,
    S_RB_CAP,
    S_RB_WR,
    S_TBL,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.func) inside
          FUNC_RD, FUNC_WR: begin
            if (sts.len_bad || sts.overrun) begin
              state_nxt = S_FINISH;
            end else if (sts.len_zero) begin
              state_nxt = (sts.func == FUNC_RD) ? S_FINISH : S_POST_WR;
            end else begin
              state_nxt = (sts.func == FUNC_RD) ? S_RD_ISSUE : S_WR;
            end
          end
          FUNC_XLATE: state_nxt = S_TBL;
          FUNC_BAD:   state_nxt = S_FINISH;
        endcase
      end
      S_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = sts.byte_last ? S_FINISH : S_RD_ISSUE;
      end
      S_WR: begin
        cmd.wr_step = 1'b1;
        if (sts.byte_last) state_nxt = S_POST_WR;
      end
      S_POST_WR: begin
        if (sts.rebuild_hit) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_RB_ISSUE;
        end else begin
          cmd.attr_wr = sts.attr_hit;
          state_nxt   = S_FINISH;
        end
      end
      S_RB_ISSUE: begin
        cmd.rd_issue = 1'b1;
        cmd.rd_slot  = 1'b1;
        state_nxt    = S_RB_CAP;
      end
      S_RB_CAP: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = sts.rb_last ? S_RB_WR : S_RB_ISSUE;
      end
      S_RB_WR: begin
        cmd.rebuild_wr = 1'b1;
        state_nxt      = S_FINISH;
      end
      S_TBL: begin
        cmd.tbl_read = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

/* hdl/itlb_dp.sv */
// Datapath of the inbound translation table: request latch, byte window memory,
// entry tables, byte counters, result logic and output register. Depends on itlb_pkg.
module itlb_dp
  import itlb_pkg::*;
#(
  parameter int ENTRIES      = ITLB_ENTRIES,
  parameter int WINDOW_BYTES = ITLB_WINDOW_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  itlb_cmd_t   cmd,
  output itlb_sts_t   sts,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_address,
  input  logic [3:0]  in_length,
  input  logic [63:0] in_write_data,
  output logic [1:0]  out_status,
  output logic [63:0] out_read_data,
  output logic [63:0] out_translated_address,
  output logic [11:0] out_user_bits
);

  localparam int WIN_AW = $clog2(WINDOW_BYTES);
  localparam int ENT_AW = $clog2(ENTRIES);
  localparam int SLOT_W = 32 - SLOT_BITS;

  // Request latch
  itlb_func_t  func_r;
  logic [63:0] addr_r;
  logic [3:0]  len_r;
  logic [63:0] wdata_r;

  logic [3:0]        idx_r;
  logic [63:0]       acc_r;
  logic [WIN_AW-1:0] clr_r;
  logic              rd_oob_r;
  logic [7:0]        mem_q_r;

  logic [7:0] win_mem [WINDOW_BYTES];

  logic [FRAME_W-1:0] frame_mem [ENTRIES];
  logic [ATTR_W-1:0]  attr_mem  [ENTRIES];
  logic [FRAME_W-1:0] frame_q_r;
  logic [ATTR_W-1:0]  attr_q_r;
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] frame_wr_r;
  logic [ENTRIES-1:0] attr_wr_r;
  logic               hit_r;
  logic               fwr_q_r;
  logic               awr_q_r;
  logic               tzero_r;

  logic [1:0]  out_status_r;
  logic [63:0] out_rdata_r;
  logic [63:0] out_xaddr_r;
  logic [11:0] out_user_r;

  logic [31:0]         off;
  logic                win_req;
  logic                len_bad;
  logic                overrun;
  logic [SLOT_W-1:0]   slot;
  logic                slot_in;
  logic [ENT_AW-1:0]   slot_idx;
  logic                rebuild_hit;
  logic                attr_hit;
  logic [WIN_AW-1:0]   byte_pos;
  logic [WIN_AW:0]     rb_pos;
  logic                rb_oob;
  logic [WIN_AW-1:0]   rd_addr;
  logic                wr_en;
  logic [WIN_AW-1:0]   wr_addr;
  logic [7:0]          wr_byte;
  logic [IDX_BITS-1:0] xidx;
  logic                x_in;
  logic [ENT_AW-1:0]   tidx;
  logic [FRAME_W-1:0]  frame_eff;
  logic [ATTR_W-1:0]   attr_eff;
  logic                xlate_ok;
  itlb_status_t        res_status;
  logic [63:0]         res_rdata;
  logic [63:0]         res_xaddr;
  logic [11:0]         res_user;

  assign off      = addr_r[31:0];
  assign win_req  = (func_r == FUNC_RD) || (func_r == FUNC_WR);
  assign len_bad  = len_r > 4'(MAX_ACCESS);
  assign overrun  = ({1'b0, off} + 33'(len_r)) > 33'(WINDOW_BYTES);

  assign slot        = off[31:SLOT_BITS];
  assign slot_in     = slot < SLOT_W'(ENTRIES);
  assign slot_idx    = ENT_AW'(slot);
  assign rebuild_hit = slot_in && (off[SLOT_BITS-1:3] == '0);
  assign attr_hit    = slot_in && (off[SLOT_BITS-1:0] == ATTR_OFFSET) && (len_r == ATTR_LEN);

  assign byte_pos = off[WIN_AW-1:0] + WIN_AW'(idx_r);
  assign rb_pos   = {off[WIN_AW:SLOT_BITS], SLOT_BITS'(0)} + (WIN_AW+1)'(idx_r[2:0]);
  // Slot bytes past the window end read as zero
  assign rb_oob   = rb_pos >= (WIN_AW+1)'(WINDOW_BYTES);
  assign rd_addr  = cmd.rd_slot ? rb_pos[WIN_AW-1:0] : byte_pos;

  assign wr_en   = cmd.clear_step || cmd.wr_step;
  assign wr_addr = cmd.clear_step ? clr_r : byte_pos;
  assign wr_byte = cmd.clear_step ? 8'h00 : wdata_r[8*idx_r[2:0] +: 8];

  assign xidx = addr_r[PAGE_BITS +: IDX_BITS];
  assign x_in = 32'(xidx) < 32'(ENTRIES);
  assign tidx = ENT_AW'(xidx);

  assign sts.func        = func_r;
  assign sts.len_zero    = (len_r == 4'd0);
  assign sts.len_bad     = len_bad;
  assign sts.overrun     = overrun;
  assign sts.byte_last   = (idx_r + 4'd1) == len_r;
  assign sts.rb_last     = (idx_r[2:0] == 3'd7);
  assign sts.rebuild_hit = rebuild_hit;
  assign sts.attr_hit    = attr_hit;
  assign sts.clear_last  = (clr_r == WIN_AW'(WINDOW_BYTES - 1));

  // Request latch, byte counter and read accumulator
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r  <= itlb_func_t'(in_func);
      addr_r  <= in_address;
      len_r   <= in_length;
      wdata_r <= in_write_data;
      acc_r   <= '0;
    end else if (cmd.rd_capture) begin
      acc_r[8*idx_r[2:0] +: 8] <= rd_oob_r ? 8'h00 : mem_q_r;
    end
    if (cmd.load_item || cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.wr_step || cmd.rd_capture) begin
      idx_r <= idx_r + 4'd1;
    end
  end

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear_step) begin
      clr_r <= clr_r + WIN_AW'(1);
    end
  end

  // Window memory
  always_ff @(posedge clk) begin
    if (wr_en) win_mem[wr_addr] <= wr_byte;
    if (cmd.rd_issue) begin
      mem_q_r  <= win_mem[rd_addr];
      rd_oob_r <= cmd.rd_slot && rb_oob;
    end
  end

  // Entry tables
  always_ff @(posedge clk) begin
    if (cmd.rebuild_wr) frame_mem[slot_idx] <= {acc_r[63:32], acc_r[31:FRAME_SHIFT]};
    if (cmd.tbl_read) frame_q_r <= frame_mem[tidx];
  end

  always_ff @(posedge clk) begin
    if (cmd.attr_wr) attr_mem[slot_idx] <= wdata_r[ATTR_W-1:0];
    if (cmd.tbl_read) attr_q_r <= attr_mem[tidx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= ENTRIES'(1);
      frame_wr_r <= '0;
      attr_wr_r  <= '0;
    end else begin
      if (cmd.rebuild_wr) begin
        valid_r[slot_idx]    <= acc_r[0];
        frame_wr_r[slot_idx] <= 1'b1;
      end
      if (cmd.attr_wr) attr_wr_r[slot_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tbl_read) begin
      hit_r   <= x_in && valid_r[tidx];
      fwr_q_r <= frame_wr_r[tidx];
      awr_q_r <= attr_wr_r[tidx];
      tzero_r <= (tidx == '0);
    end
  end

  // Unwritten entries hold their reset contents
  assign frame_eff = fwr_q_r ? frame_q_r : (tzero_r ? FRAME0_RST : '0);
  assign attr_eff  = awr_q_r ? attr_q_r  : (tzero_r ? ATTR0_RST  : '0);

  always_comb begin
    res_status = ST_OK;
    if ((func_r == FUNC_BAD) || (win_req && len_bad)) begin
      res_status = ST_CMD_ERR;
    end else if (win_req && overrun) begin
      res_status = ST_ADDR_ERR;
    end else if ((func_r == FUNC_XLATE) && !hit_r) begin
      res_status = ST_ADDR_ERR;
    end
  end

  assign xlate_ok  = (func_r == FUNC_XLATE) && hit_r;
  assign res_rdata = ((func_r == FUNC_RD) && (res_status == ST_OK)) ? acc_r : '0;
  assign res_xaddr = xlate_ok ?
                     (({frame_eff, FRAME_SHIFT'(0)} & ~PG_OFFSET_MASK) |
                      (addr_r & PG_OFFSET_MASK)) : '0;
  assign res_user  = xlate_ok ? {attr_eff[11:4], 2'b00, attr_eff[1:0]} : '0;

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status_r <= res_status;
      out_rdata_r  <= res_rdata;
      out_xaddr_r  <= res_xaddr;
      out_user_r   <= res_user;
    end
  end

  assign out_status             = out_status_r;
  assign out_read_data          = out_rdata_r;
  assign out_translated_address = out_xaddr_r;
  assign out_user_bits          = out_user_r;

endmodule
